// ===== sv/sit_pkg.sv =====
// shared types, constants and helpers for the segment intersection test
`default_nettype none

package sit_pkg;

  localparam int COORD_BITS = 10;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  localparam int IN_FIELDS = 8;
  localparam int IN_TDATA_W = ((IN_FIELDS * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS = 2;
  localparam int OUT_TDATA_W = 8;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef enum logic [1:0] {
    ORI_ZERO = 2'd0,
    ORI_POS  = 2'd1,
    ORI_NEG  = 2'd2
  } orient_t;

  // q lies inside the box spanned by p and r
  function automatic logic within_box(point_t p, point_t q, point_t r);
    coord_t lox;
    coord_t hix;
    coord_t loy;
    coord_t hiy;
    lox = (p.x < r.x) ? p.x : r.x;
    hix = (p.x < r.x) ? r.x : p.x;
    loy = (p.y < r.y) ? p.y : r.y;
    hiy = (p.y < r.y) ? r.y : p.y;
    return (q.x >= lox) && (q.x <= hix) && (q.y >= loy) && (q.y <= hiy);
  endfunction

endpackage

`default_nettype wire

// ===== sv/sit_orient.sv =====
// orientation sign of point r against the directed line p to q
`default_nettype none

module sit_orient (
  input  sit_pkg::point_t  p,
  input  sit_pkg::point_t  q,
  input  sit_pkg::point_t  r,
  output sit_pkg::orient_t orient
);

  logic signed [sit_pkg::DIFF_BITS-1:0]  dy_qp;
  logic signed [sit_pkg::DIFF_BITS-1:0]  dx_rq;
  logic signed [sit_pkg::DIFF_BITS-1:0]  dx_qp;
  logic signed [sit_pkg::DIFF_BITS-1:0]  dy_rq;
  logic signed [sit_pkg::PROD_BITS-1:0]  prod_a;
  logic signed [sit_pkg::PROD_BITS-1:0]  prod_b;
  logic signed [sit_pkg::CROSS_BITS-1:0] cross_val;

  assign dy_qp = $signed({1'b0, q.y}) - $signed({1'b0, p.y});
  assign dx_rq = $signed({1'b0, r.x}) - $signed({1'b0, q.x});
  assign dx_qp = $signed({1'b0, q.x}) - $signed({1'b0, p.x});
  assign dy_rq = $signed({1'b0, r.y}) - $signed({1'b0, q.y});

  assign prod_a = dy_qp * dx_rq;
  assign prod_b = dx_qp * dy_rq;

  // one bit of growth keeps the difference exact
  assign cross_val = sit_pkg::CROSS_BITS'(prod_a) - sit_pkg::CROSS_BITS'(prod_b);

  always_comb begin
    if (cross_val == '0) begin
      orient = sit_pkg::ORI_ZERO;
    end else if (cross_val[sit_pkg::CROSS_BITS-1]) begin
      orient = sit_pkg::ORI_NEG;
    end else begin
      orient = sit_pkg::ORI_POS;
    end
  end

endmodule

`default_nettype wire

// ===== sv/segment_intersection_test.sv =====
// top level: two-segment intersection test with stream handshakes
//
// Each input transaction carries two segments, A and B, as four grid points
// with unsigned 10-bit coordinates. The block answers with one result
// transaction: crosses is high when the segments touch or cross, and
// shared_endpoint is high when an endpoint of A equals an endpoint of B; in
// that case crosses is forced low. Collinear overlap counts as crossing, and
// a segment whose two ends coincide is handled as a single point. The block
// takes one transaction per clock cycle for as long as the result side keeps
// tready high. An accepted transaction is stored in the input register, and
// its result moves into the result register, which drives out_tvalid, once
// that register is free. The per-item work is the four orientation tests
// (two 11x11 signed products and a subtract each) plus the endpoint and box
// compares, all between those two registers. When the result side stalls,
// the input register still fills, so one more transaction is taken before
// in_tready drops.
`default_nettype none

module segment_intersection_test (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [sit_pkg::IN_TDATA_W-1:0]   in_tdata,
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // crosses, shared_endpoint, zero padding
  output logic [sit_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int CB = sit_pkg::COORD_BITS;

  // input register stage
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  sit_pkg::point_t  a_start_r;
  sit_pkg::point_t  a_end_r;
  sit_pkg::point_t  b_start_r;
  sit_pkg::point_t  b_end_r;

  // result register stage
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             crosses_r;
  logic             shared_r;

  logic             out_move;
  logic             s1_move;
  logic             in_take;

  sit_pkg::orient_t o1;
  sit_pkg::orient_t o2;
  sit_pkg::orient_t o3;
  sit_pkg::orient_t o4;
  logic             shared;
  logic             hit;

  // result register empties or is being drained this cycle
  assign out_move  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_move;
  assign in_tready = !s1_valid_r || out_move;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_move) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // unpack the points, field order from the lowest bit up
  always_ff @(posedge clk) begin
    if (in_take) begin
      a_start_r.x <= in_tdata[0*CB +: CB];
      a_start_r.y <= in_tdata[1*CB +: CB];
      a_end_r.x   <= in_tdata[2*CB +: CB];
      a_end_r.y   <= in_tdata[3*CB +: CB];
      b_start_r.x <= in_tdata[4*CB +: CB];
      b_start_r.y <= in_tdata[5*CB +: CB];
      b_end_r.x   <= in_tdata[6*CB +: CB];
      b_end_r.y   <= in_tdata[7*CB +: CB];
    end
  end

  // orientation of each endpoint against the other segment
  sit_orient u_orient_1 (.p(a_start_r), .q(a_end_r), .r(b_start_r), .orient(o1));
  sit_orient u_orient_2 (.p(a_start_r), .q(a_end_r), .r(b_end_r),   .orient(o2));
  sit_orient u_orient_3 (.p(b_start_r), .q(b_end_r), .r(a_start_r), .orient(o3));
  sit_orient u_orient_4 (.p(b_start_r), .q(b_end_r), .r(a_end_r),   .orient(o4));

  assign shared = (a_start_r == b_start_r) || (a_start_r == b_end_r) ||
                  (a_end_r == b_start_r)   || (a_end_r == b_end_r);

  always_comb begin
    hit = 1'b0;
    if (!shared) begin
      // general case: each segment straddles the other's line
      if ((o1 != o2) && (o3 != o4)) begin
        hit = 1'b1;
      end
      // collinear endpoint lying on the other segment
      if ((o1 == sit_pkg::ORI_ZERO) && sit_pkg::within_box(a_start_r, b_start_r, a_end_r)) begin
        hit = 1'b1;
      end
      if ((o2 == sit_pkg::ORI_ZERO) && sit_pkg::within_box(a_start_r, b_end_r, a_end_r)) begin
        hit = 1'b1;
      end
      if ((o3 == sit_pkg::ORI_ZERO) && sit_pkg::within_box(b_start_r, a_start_r, b_end_r)) begin
        hit = 1'b1;
      end
      if ((o4 == sit_pkg::ORI_ZERO) && sit_pkg::within_box(b_start_r, a_end_r, b_end_r)) begin
        hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      crosses_r <= hit;
      shared_r  <= shared;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(sit_pkg::OUT_TDATA_W - sit_pkg::OUT_FIELDS){1'b0}}, shared_r, crosses_r};

  // a shared endpoint always clears the crossing flag
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(crosses_r && shared_r))
    else $error("crosses and shared_endpoint both set");

  // a held item in the input register is not dropped while the output stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_move) |=> s1_valid_r)
    else $error("input register item lost during stall");

  // backpressure only when both stages are full and the output is blocked
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("in_tready low without a full pipeline");

  // an item leaving the input register shows up as a valid result
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("result register did not capture item");

endmodule

`default_nettype wire
